// ===== rtl/barcode_hamming_one_corrector_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Barcode corrector assertion macros
// Shared property forms used by the checker of the barcode corrector.
// ----------------------------------------------------------------------------
`ifndef BARCODE_HAMMING_ONE_CORRECTOR_UNIT_DEFINES_SVH
`define BARCODE_HAMMING_ONE_CORRECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on i_clk and disabled in reset.
`define BHC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk and disabled in reset.
`define BHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bhc_pkg.sv =====
// ----------------------------------------------------------------------------
// Barcode corrector package
// Sizes, codes and link types shared by the cells, the top level and checker.
// ----------------------------------------------------------------------------
package bhc_pkg;

    localparam int NCELL        = 16;
    localparam int CELL_W       = $clog2(NCELL);
    localparam int ROWS         = 128;
    localparam int ROW_W        = $clog2(ROWS);
    localparam int MAX_ENTRIES  = NCELL * ROWS;
    localparam int IDX_W        = $clog2(MAX_ENTRIES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int SYM_W        = 3;
    localparam int NSYM         = 16;
    localparam int BC_W         = NSYM * SYM_W;
    localparam int LEN_W        = 5;
    localparam int LAST_BASE    = 4;
    localparam int DRAIN_CYCLES = NCELL + 1;
    localparam int DRN_W        = $clog2(DRAIN_CYCLES + 1);
    localparam int STAT_W       = 2;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUP  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic [ROW_W-1:0] row;
        logic             lookup;
        logic [BC_W-1:0]  sym;
        logic [LEN_W-1:0] len;
    } t_scan;

    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] col;
        logic [ROW_W-1:0]  row;
        logic [BC_W-1:0]   sym;
        logic [LEN_W-1:0]  len;
    } t_wr;

    typedef struct packed {
        logic              hit;
        logic              exact;
        logic [ROW_W-1:0]  row;
        logic [CELL_W-1:0] col;
        logic [BC_W-1:0]   sym;
    } t_link;

endpackage

// ===== rtl/bhc_cell.sv =====
// ----------------------------------------------------------------------------
// Barcode corrector cell
// Holds one column of the whitelist, compares its rows against the query and
// passes the earliest match found so far to its neighbor every cycle.
// ----------------------------------------------------------------------------
module bhc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bhc_pkg::CELL_W-1:0] i_cell_id,
    input  bhc_pkg::t_scan             i_scan,
    input  logic [bhc_pkg::CNT_W-1:0]  i_count,
    input  bhc_pkg::t_wr               i_wr,
    input  bhc_pkg::t_link             i_link,
    output bhc_pkg::t_link             o_link
);
    import bhc_pkg::*;

    function automatic logic near_match(logic [BC_W-1:0] q, logic [BC_W-1:0] s);
        logic [NSYM-1:0] diff;
        logic            bad;
        bad = 1'b0;
        for (int i = 0; i < NSYM; i++) begin
            diff[i] = (q[i*SYM_W +: SYM_W] != s[i*SYM_W +: SYM_W]);
            bad     = bad | (diff[i] && (q[i*SYM_W +: SYM_W] > SYM_W'(LAST_BASE)));
        end
        return !bad && ((diff & (diff - NSYM'(1))) == '0);
    endfunction

    logic [BC_W-1:0]   r_mem_sym [ROWS];
    logic [LEN_W-1:0]  r_mem_len [ROWS];
    logic [BC_W-1:0]   r_rd_sym;
    logic [LEN_W-1:0]  r_rd_len;

    logic              r_cmp_valid;
    logic              r_cmp_first;
    logic [ROW_W-1:0]  r_cmp_row;

    logic              r_loc_hit;
    logic              r_loc_exact;
    logic [ROW_W-1:0]  r_loc_row;
    logic [BC_W-1:0]   r_loc_sym;

    logic              r_link_hit;
    logic              r_link_exact;
    logic [ROW_W-1:0]  r_link_row;
    logic [CELL_W-1:0] r_link_cell;
    logic [BC_W-1:0]   r_link_sym;

    logic              entry_ok;
    logic              len_eq;
    logic              exact_c;
    logic              match_c;
    logic              take_local;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.col == i_cell_id)) begin
            r_mem_sym[i_wr.row] <= i_wr.sym;
            r_mem_len[i_wr.row] <= i_wr.len;
        end
        r_rd_sym <= r_mem_sym[i_scan.row];
        r_rd_len <= r_mem_len[i_scan.row];
    end

    always_comb begin
        entry_ok = (CNT_W'({r_cmp_row, i_cell_id}) < i_count);
        len_eq   = (r_rd_len == i_scan.len);
        exact_c  = entry_ok && len_eq && (r_rd_sym == i_scan.sym);
        if (i_scan.lookup == CMD_LOOKUP) begin
            match_c = entry_ok && len_eq && near_match(i_scan.sym, r_rd_sym);
        end else begin
            match_c = exact_c;
        end
        take_local = r_loc_hit && (!i_link.hit || (r_loc_row < i_link.row));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid  <= 1'b0;
            r_loc_hit    <= 1'b0;
            r_loc_exact  <= 1'b0;
            r_link_hit   <= 1'b0;
            r_link_exact <= 1'b0;
        end else begin
            r_cmp_valid  <= i_scan.valid;
            if (r_cmp_valid) begin
                if (r_cmp_first) begin
                    r_loc_hit   <= match_c;
                    r_loc_exact <= exact_c;
                end else begin
                    r_loc_hit   <= r_loc_hit | match_c;
                    r_loc_exact <= r_loc_exact | exact_c;
                end
            end
            r_link_hit   <= i_link.hit | r_loc_hit;
            r_link_exact <= i_link.exact | r_loc_exact;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_first <= i_scan.first;
        r_cmp_row   <= i_scan.row;
        if (r_cmp_valid && (r_cmp_first || !r_loc_hit)) begin
            r_loc_row <= r_cmp_row;
            r_loc_sym <= r_rd_sym;
        end
        if (take_local) begin
            r_link_row  <= r_loc_row;
            r_link_cell <= i_cell_id;
            r_link_sym  <= r_loc_sym;
        end else begin
            r_link_row  <= i_link.row;
            r_link_cell <= i_link.col;
            r_link_sym  <= i_link.sym;
        end
    end

    assign o_link.hit   = r_link_hit;
    assign o_link.exact = r_link_exact;
    assign o_link.row   = r_link_row;
    assign o_link.col   = r_link_cell;
    assign o_link.sym   = r_link_sym;

endmodule

// ===== rtl/barcode_hamming_one_corrector_unit.sv =====
// ----------------------------------------------------------------------------
// Barcode whitelist corrector
// Stores canonical barcodes and finds the earliest one within one mismatch.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Command
// load appends a barcode to the whitelist, command lookup searches it.
// The whitelist lives in a row of 16 cells, each holding one column of
// 128 rows; entry n sits in cell n mod 16, row n / 16. A request sweeps rows
// 0 up to the last occupied row, one row per cycle in all cells at once,
// then the last compare and the ripple of the earliest match down the cell
// chain follow. Busy stays high from the accepting edge until the result
// appears, in the cycle busy falls; a new request can be taken in that
// same cycle. Each result is shown for exactly one cycle with o_valid high;
// the receiver cannot stall it. Reset empties the whitelist at once, with no
// clearing pass, and drops any request in progress.
// ----------------------------------------------------------------------------
module barcode_hamming_one_corrector_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_command,
    input  logic [bhc_pkg::BC_W-1:0]   i_barcode,
    input  logic [bhc_pkg::LEN_W-1:0]  i_length,
    output logic                       o_valid,
    output logic                       o_found,
    output logic                       o_exact,
    output logic [bhc_pkg::BC_W-1:0]   o_canonical_barcode,
    output logic [bhc_pkg::LEN_W-1:0]  o_canonical_length,
    output logic [bhc_pkg::IDX_W-1:0]  o_entry_index,
    output logic [bhc_pkg::STAT_W-1:0] o_status
);
    import bhc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    t_state            r_state;
    logic              r_cmd;
    logic [BC_W-1:0]   r_bc;
    logic [LEN_W-1:0]  r_len;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  r_last_row;
    logic [DRN_W-1:0]  r_drain;
    logic [CNT_W-1:0]  r_count;

    logic [LEN_W-1:0]  len_c;
    logic [BC_W-1:0]   bc_m;
    logic [CNT_W-1:0]  count_m1;
    logic              finish;
    t_scan             scan;
    t_wr               wr;
    t_link             links [NCELL+1];
    t_link             tail;

    always_comb begin
        len_c = (i_length > LEN_W'(NSYM)) ? LEN_W'(NSYM) : i_length;
        for (int i = 0; i < NSYM; i++) begin
            bc_m[i*SYM_W +: SYM_W] = (LEN_W'(i) < len_c) ? i_barcode[i*SYM_W +: SYM_W] : '0;
        end
        count_m1 = r_count - CNT_W'(1);
    end

    assign busy   = (r_state != S_IDLE);
    assign finish = (r_state == S_DRAIN) && (r_drain == '0);
    assign tail   = links[NCELL];

    always_comb begin
        scan.valid  = (r_state == S_SCAN);
        scan.first  = (r_row == '0);
        scan.row    = r_row;
        scan.lookup = r_cmd;
        scan.sym    = r_bc;
        scan.len    = r_len;

        wr.en   = finish && (r_cmd == CMD_LOAD) && !tail.hit
                  && (r_count != CNT_W'(MAX_ENTRIES));
        wr.col  = r_count[CELL_W-1:0];
        wr.row  = r_count[IDX_W-1:CELL_W];
        wr.sym  = r_bc;
        wr.len  = r_len;
    end

    assign links[0] = '0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        bhc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (CELL_W'(g)),
            .i_scan    (scan),
            .i_count   (r_count),
            .i_wr      (wr),
            .i_link    (links[g]),
            .o_link    (links[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd      <= i_command;
                        r_bc       <= bc_m;
                        r_len      <= len_c;
                        r_row      <= '0;
                        r_last_row <= (r_count == '0) ? '0 : count_m1[IDX_W-1:CELL_W];
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_row == r_last_row) begin
                        r_drain <= DRN_W'(DRAIN_CYCLES);
                        r_state <= S_DRAIN;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_drain != '0) begin
                        r_drain <= r_drain - DRN_W'(1);
                    end else begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_cmd == CMD_LOAD) begin
                            o_found             <= 1'b0;
                            o_exact             <= 1'b0;
                            o_canonical_barcode <= '0;
                            o_canonical_length  <= '0;
                            if (tail.hit) begin
                                o_status      <= ST_DUP;
                                o_entry_index <= {tail.row, tail.col};
                            end else if (r_count == CNT_W'(MAX_ENTRIES)) begin
                                o_status      <= ST_FULL;
                                o_entry_index <= '0;
                            end else begin
                                o_status      <= ST_DONE;
                                o_entry_index <= r_count[IDX_W-1:0];
                                r_count       <= r_count + CNT_W'(1);
                            end
                        end else begin
                            o_found             <= tail.hit;
                            o_exact             <= tail.exact;
                            o_canonical_barcode <= tail.hit ? tail.sym : '0;
                            o_canonical_length  <= tail.hit ? r_len : '0;
                            o_entry_index       <= tail.hit ? {tail.row, tail.col} : '0;
                            o_status            <= ST_DONE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/bhc_checker.sv =====
// ----------------------------------------------------------------------------
// Barcode corrector port checker
// Watches the top-level ports for request and result ordering rules.
// ----------------------------------------------------------------------------
`include "barcode_hamming_one_corrector_unit_defines.svh"

module bhc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic                       o_found,
    input logic                       o_exact,
    input logic [bhc_pkg::BC_W-1:0]   o_canonical_barcode,
    input logic [bhc_pkg::LEN_W-1:0]  o_canonical_length,
    input logic [bhc_pkg::STAT_W-1:0] o_status
);
    import bhc_pkg::*;

    `BHC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `BHC_ASSERT_IMPLIES(a_strobe_end, o_valid, !busy && $past(busy), "result outside request end")
    `BHC_ASSERT_IMPLIES(a_fall_strobe, $fell(busy), o_valid, "request ended without a result")
    `BHC_ASSERT_IMPLIES(a_miss_zero, o_valid && !o_found, (o_canonical_barcode == '0) && (o_canonical_length == '0), "miss carries a canonical entry")
    `BHC_ASSERT_IMPLIES(a_refused_plain, o_valid && (o_status != ST_DONE), !o_found && !o_exact, "refused load reports a match")

endmodule

bind barcode_hamming_one_corrector_unit bhc_checker u_bhc_checker (.*);

// ===== dv/bhc_whitelist_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barcode whitelist monitor
// Watches the request and result ports of the barcode corrector. It keeps
// its own copy of the whitelist and works out the answer to every accepted
// request. Each result is compared field by field with the oldest answer due.
// ----------------------------------------------------------------------------
module bhc_whitelist_monitor
    import bhc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              i_command,
    input  logic [BC_W-1:0]   i_barcode,
    input  logic [LEN_W-1:0]  i_length,
    input  logic              o_valid,
    input  logic              o_found,
    input  logic              o_exact,
    input  logic [BC_W-1:0]   o_canonical_barcode,
    input  logic [LEN_W-1:0]  o_canonical_length,
    input  logic [IDX_W-1:0]  o_entry_index,
    input  logic [STAT_W-1:0] o_status,
    output int                o_pending,
    output int                o_mismatches
);

    typedef struct packed {
        logic              found;
        logic              exact;
        logic [BC_W-1:0]   canon_bc;
        logic [LEN_W-1:0]  canon_len;
        logic [IDX_W-1:0]  index;
        logic [STAT_W-1:0] status;
    } t_answer;

    logic [BC_W-1:0]  whitelist_bc  [MAX_ENTRIES];
    logic [LEN_W-1:0] whitelist_len [MAX_ENTRIES];
    int               whitelist_count = 0;
    t_answer          answers_due[$];
    int               mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic bit within_one(logic [BC_W-1:0] query, logic [BC_W-1:0] entry, int n);
        int               diffs;
        int               i;
        logic [SYM_W-1:0] q;
        logic [SYM_W-1:0] e;
        diffs = 0;
        for (i = 0; i < n; i++) begin
            q = query[i*SYM_W +: SYM_W];
            e = entry[i*SYM_W +: SYM_W];
            if (q != e) begin
                if (q > LAST_BASE)
                    return 1'b0;
                diffs++;
                if (diffs > 1)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_answer resolve_request(logic cmd, logic [BC_W-1:0] raw_bc,
                                                logic [LEN_W-1:0] raw_len);
        t_answer         ans;
        int              n;
        int              i;
        logic [BC_W-1:0] query;
        bit              dup;
        ans   = '0;
        n     = (raw_len > NSYM) ? NSYM : int'(raw_len);
        query = '0;
        for (i = 0; i < n; i++)
            query[i*SYM_W +: SYM_W] = raw_bc[i*SYM_W +: SYM_W];
        if (cmd == CMD_LOAD) begin
            dup = 1'b0;
            for (i = 0; i < whitelist_count && !dup; i++) begin
                if (whitelist_len[i] == n && whitelist_bc[i] == query) begin
                    dup       = 1'b1;
                    ans.index = IDX_W'(i);
                end
            end
            if (dup) begin
                ans.status = ST_DUP;
            end else if (whitelist_count >= MAX_ENTRIES) begin
                ans.status = ST_FULL;
            end else begin
                whitelist_bc[whitelist_count]  = query;
                whitelist_len[whitelist_count] = LEN_W'(n);
                ans.index                      = IDX_W'(whitelist_count);
                whitelist_count++;
            end
        end else begin
            for (i = 0; i < whitelist_count; i++) begin
                if (whitelist_len[i] == n) begin
                    if (whitelist_bc[i] == query)
                        ans.exact = 1'b1;
                    if (!ans.found && within_one(query, whitelist_bc[i], n)) begin
                        ans.found     = 1'b1;
                        ans.canon_bc  = whitelist_bc[i];
                        ans.canon_len = LEN_W'(n);
                        ans.index     = IDX_W'(i);
                    end
                end
            end
        end
        return ans;
    endfunction

    task automatic compare_field(string field, logic [BC_W-1:0] want, logic [BC_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            whitelist_count = 0;
            answers_due.delete();
        end else begin
            if (o_valid) begin
                if (answers_due.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    compare_field("found", want.found, o_found);
                    compare_field("exact", want.exact, o_exact);
                    compare_field("canonical_barcode", want.canon_bc, o_canonical_barcode);
                    compare_field("canonical_length", want.canon_len, o_canonical_length);
                    compare_field("entry_index", want.index, o_entry_index);
                    compare_field("status", want.status, o_status);
                end
            end
            if (start && !busy)
                answers_due.push_back(resolve_request(i_command, i_barcode, i_length));
        end
        o_pending <= answers_due.size();
    end

endmodule

// ===== dv/barcode_hamming_one_corrector_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barcode corrector testbench
// Drives load and lookup requests into the barcode corrector: a directed set
// of corner cases, then random requests built mostly from barcodes already
// loaded with zero, one or two symbols changed. A monitor predicts and
// checks every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module barcode_hamming_one_corrector_unit_tb;
    import bhc_pkg::*;

    localparam real CLK_HALF       = 2.0;
    localparam int  RESET_CYCLES   = 5;
    localparam int  RANDOM_ITEMS   = 827;
    localparam int  QUIET_FIRST    = 250;
    localparam int  QUIET_LAST     = 400;
    localparam int  STALL_LIMIT    = 2000;
    localparam int  TAIL_CYCLES    = ROWS + 2 * DRAIN_CYCLES;

    localparam logic [SYM_W-1:0] SYM_A   = 3'd0;
    localparam logic [SYM_W-1:0] SYM_C   = 3'd1;
    localparam logic [SYM_W-1:0] SYM_G   = 3'd2;
    localparam logic [SYM_W-1:0] SYM_T   = 3'd3;
    localparam logic [SYM_W-1:0] SYM_N   = 3'd4;
    localparam logic [SYM_W-1:0] SYM_RSV = 3'd5;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    logic              i_command = CMD_LOAD;
    logic [BC_W-1:0]   i_barcode = '0;
    logic [LEN_W-1:0]  i_length  = '0;
    logic              o_valid;
    logic              o_found;
    logic              o_exact;
    logic [BC_W-1:0]   o_canonical_barcode;
    logic [LEN_W-1:0]  o_canonical_length;
    logic [IDX_W-1:0]  o_entry_index;
    logic [STAT_W-1:0] o_status;

    int                requests_open;
    int                mismatch_total;
    int                quiet_cycles = 0;
    bit                idle_enable  = 1'b1;
    logic [BC_W-1:0]   loaded_bc[$];
    logic [LEN_W-1:0]  loaded_len[$];

    always #(CLK_HALF) i_clk = ~i_clk;

    barcode_hamming_one_corrector_unit uut (.*);

    bhc_whitelist_monitor monitor (
        .o_pending    (requests_open),
        .o_mismatches (mismatch_total),
        .*
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [SYM_W-1:0] random_code();
        if ($urandom_range(9) == 0)
            return SYM_W'($urandom_range(2**SYM_W - 1, LAST_BASE + 1));
        return SYM_W'($urandom_range(LAST_BASE));
    endfunction

    function automatic logic [BC_W-1:0] scribble_above(logic [BC_W-1:0] bc, int n);
        int i;
        for (i = n; i < NSYM; i++)
            bc[i*SYM_W +: SYM_W] = SYM_W'($urandom);
        return bc;
    endfunction

    function automatic logic [BC_W-1:0] change_symbol(logic [BC_W-1:0] bc, int n);
        if (n == 0)
            return bc;
        bc[$urandom_range(n - 1)*SYM_W +: SYM_W] = random_code();
        return bc;
    endfunction

    function automatic logic [BC_W-1:0] random_symbols(logic [LEN_W-1:0] len);
        logic [BC_W-1:0] bc;
        int              i;
        bc = '0;
        for (i = 0; i < NSYM && i < len; i++)
            bc[i*SYM_W +: SYM_W] = random_code();
        if ($urandom_range(9) < 3)
            bc = scribble_above(bc, i);
        return bc;
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return LEN_W'($urandom_range(1));
        if (roll < 70)
            return LEN_W'($urandom_range(5, 2));
        if (roll < 90)
            return LEN_W'($urandom_range(NSYM, 6));
        return LEN_W'($urandom_range(2**LEN_W - 1, NSYM + 1));
    endfunction

    task automatic send_request(logic cmd, logic [BC_W-1:0] bc, logic [LEN_W-1:0] len);
        int gap;
        if (idle_enable && $urandom_range(99) < 8) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : 1;
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_barcode <= bc;
        i_length  <= len;
        do @(posedge i_clk); while (busy);
        if (cmd == CMD_LOAD) begin
            loaded_bc.push_back(bc);
            loaded_len.push_back(len);
        end
    endtask

    task automatic random_request();
        logic             cmd;
        logic [BC_W-1:0]  bc;
        logic [LEN_W-1:0] len;
        int               roll;
        int               pick;
        int               n;
        cmd = ($urandom_range(99) < 35) ? CMD_LOAD : CMD_LOOKUP;
        if (loaded_bc.size() != 0
                && $urandom_range(99) < ((cmd == CMD_LOAD) ? 20 : 70)) begin
            pick = $urandom_range(loaded_bc.size() - 1);
            bc   = loaded_bc[pick];
            len  = loaded_len[pick];
            n    = (len > NSYM) ? NSYM : int'(len);
            if (cmd == CMD_LOOKUP) begin
                roll = $urandom_range(99);
                repeat ((roll < 40) ? 0 : (roll < 85) ? 1 : 2)
                    bc = change_symbol(bc, n);
                if (n == NSYM && $urandom_range(3) == 0)
                    len = LEN_W'($urandom_range(2**LEN_W - 1, NSYM + 1));
            end
            if ($urandom_range(2) == 0)
                bc = scribble_above(bc, n);
        end else begin
            len = pick_length();
            bc  = random_symbols(len);
        end
        send_request(cmd, bc, len);
    endtask

    initial begin
        int k;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(CMD_LOOKUP, BC_W'({SYM_T, SYM_G, SYM_C, SYM_A}), LEN_W'(4));
        send_request(CMD_LOAD, '1, LEN_W'(0));
        send_request(CMD_LOOKUP, '0, LEN_W'(0));
        send_request(CMD_LOAD, '1, LEN_W'(NSYM));
        send_request(CMD_LOAD, '1, '1);
        send_request(CMD_LOOKUP, {{30{1'b1}}, SYM_A, {15{1'b1}}}, LEN_W'(NSYM));
        send_request(CMD_LOOKUP, {{30{1'b1}}, SYM_RSV, {15{1'b1}}}, LEN_W'(NSYM));
        send_request(CMD_LOOKUP, '1, LEN_W'(NSYM + 4));
        send_request(CMD_LOAD, BC_W'({SYM_G, SYM_C, SYM_A}), LEN_W'(3));
        send_request(CMD_LOAD, BC_W'({SYM_T, SYM_C, SYM_A}), LEN_W'(3));
        send_request(CMD_LOOKUP, BC_W'({SYM_N, SYM_C, SYM_A}), LEN_W'(3));
        send_request(CMD_LOOKUP, BC_W'({SYM_T, SYM_C, SYM_A}), LEN_W'(3));
        send_request(CMD_LOOKUP, BC_W'({SYM_A, SYM_G, SYM_A}), LEN_W'(3));
        send_request(CMD_LOAD, {{39{1'b1}}, SYM_G, SYM_C, SYM_A}, LEN_W'(3));
        send_request(CMD_LOAD, BC_W'(SYM_N), LEN_W'(1));
        send_request(CMD_LOOKUP, BC_W'(SYM_RSV), LEN_W'(1));
        send_request(CMD_LOOKUP, BC_W'(SYM_A), LEN_W'(1));
        send_request(CMD_LOAD, BC_W'({SYM_RSV, SYM_RSV}), LEN_W'(2));
        send_request(CMD_LOOKUP, BC_W'({SYM_A, SYM_RSV}), LEN_W'(2));
        send_request(CMD_LOOKUP, BC_W'({SYM_N, SYM_N}), LEN_W'(2));
        send_request(CMD_LOAD, '0, LEN_W'(NSYM));
        send_request(CMD_LOOKUP, {SYM_N, 45'd0}, LEN_W'(NSYM));
        send_request(CMD_LOOKUP, {SYM_A, {45{1'b1}}}, LEN_W'(NSYM));

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            idle_enable = (k < QUIET_FIRST || k >= QUIET_LAST);
            random_request();
        end

        start <= 1'b0;
        while (requests_open != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_total == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
